FILE: src/lcdns_pkg.sv
package lcdns_pkg;

    typedef enum logic [1:0] {
        REQ_COMMAND = 2'd0,
        REQ_CHAR    = 2'd1,
        REQ_GOTO    = 2'd2,
        REQ_INIT    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_PULSE_HOLD     = 2'd0,
        CFG_COMMAND_SETTLE = 2'd1,
        CFG_CHAR_SETTLE    = 2'd2,
        CFG_INIT_WAIT      = 2'd3
    } t_cfg_index;

    localparam int CFG_W  = 10;
    localparam int HOLD_W = 11;
    localparam int STEP_W = 5;

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0F;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] ROW0_BASE        = 8'h80;
    localparam logic [7:0] ROW1_BASE        = 8'hC0;
    localparam logic [3:0] INIT_NIBBLE      = 4'h2;

    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd18;
    localparam logic [STEP_W-1:0] INIT_PRELUDE   = 5'd3;

    localparam logic [CFG_W-1:0] RST_PULSE_HOLD     = 10'd1;
    localparam logic [CFG_W-1:0] RST_COMMAND_SETTLE = 10'd5;
    localparam logic [CFG_W-1:0] RST_CHAR_SETTLE    = 10'd1;
    localparam logic [CFG_W-1:0] RST_INIT_WAIT      = 10'd100;

    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] data;
    } t_job;

    typedef struct packed {
        logic [CFG_W-1:0] pulse_hold;
        logic [CFG_W-1:0] command_settle;
        logic [CFG_W-1:0] char_settle;
        logic [CFG_W-1:0] init_wait;
    } t_cfg;

    typedef struct packed {
        logic              rs;
        logic              en;
        logic [3:0]        nibble;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } t_phase;

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0: c = CMD_FUNCTION_SET;
            2'd1: c = CMD_DISPLAY_ON;
            2'd2: c = CMD_CLEAR;
            default: c = CMD_ENTRY_MODE;
        endcase
        return c;
    endfunction

endpackage

FILE: src/lcdns_front.sv
module lcdns_front
    import lcdns_pkg::*;
(
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_byte_value,
    input  logic       i_row,
    input  logic [5:0] i_col,
    output logic       o_push,
    output t_job       o_job,
    input  logic       i_full
);

    t_req req;

    assign req     = t_req'(i_req_type);
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_job.init = 1'b0;
        o_job.rs   = 1'b0;
        o_job.data = i_byte_value;
        case (req)
            REQ_COMMAND: begin
                o_job.rs = 1'b0;
            end
            REQ_CHAR: begin
                o_job.rs = 1'b1;
            end
            REQ_GOTO: begin
                // set ddram address command
                o_job.data = (i_row ? ROW1_BASE : ROW0_BASE) + {2'b00, i_col};
            end
            default: begin
                o_job.init = 1'b1;
                o_job.data = 8'h00;
            end
        endcase
    end

endmodule

FILE: src/lcdns_queue.sv
module lcdns_queue
    import lcdns_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop && o_valid) begin
                r_rd <= ~r_rd;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: src/lcdns_back.sv
module lcdns_back
    import lcdns_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_job_valid,
    input  t_job   i_job,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_stall,
    output t_phase o_phase
);

    t_job              r_job;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_phase            r_out;

    logic              adv;
    logic              last;
    logic [STEP_W-1:0] k;
    logic [1:0]        sub;
    logic [1:0]        idx;
    logic [7:0]        cur_byte;
    logic [HOLD_W-1:0] pulse;
    logic [HOLD_W-1:0] cmd_settle;
    logic [HOLD_W-1:0] chr_settle;
    logic [HOLD_W-1:0] wait_hold;
    t_phase            ph;

    assign pulse      = {1'b0, i_cfg.pulse_hold};
    assign cmd_settle = {1'b0, i_cfg.command_settle};
    assign chr_settle = {1'b0, i_cfg.char_settle};
    assign wait_hold  = {1'b0, i_cfg.init_wait};

    assign adv   = r_busy && (!r_out_valid || !i_stall);
    assign last  = (r_step == (r_job.init ? INIT_LAST_STEP : BYTE_LAST_STEP));
    assign o_pop = i_job_valid && (!r_busy || (adv && last));

    assign k        = r_job.init ? (r_step - INIT_PRELUDE) : r_step;
    assign sub      = k[1:0];
    assign idx      = k[3:2];
    assign cur_byte = r_job.init ? init_cmd(idx) : r_job.data;

    always_comb begin
        ph.rs     = r_job.rs;
        ph.en     = ~sub[0];
        ph.nibble = sub[1] ? cur_byte[3:0] : cur_byte[7:4];
        ph.hold   = pulse;
        ph.last   = last;
        if (sub == 2'd3) begin
            if (r_job.init) begin
                ph.hold = (idx != 2'd3) ? (cmd_settle + wait_hold) : cmd_settle;
            end else begin
                ph.hold = r_job.rs ? chr_settle : cmd_settle;
            end
        end
        if (r_job.init && (r_step < INIT_PRELUDE)) begin
            ph.rs = 1'b0;
            case (r_step[1:0])
                2'd0: begin
                    // power-up wait
                    ph.en     = 1'b0;
                    ph.nibble = 4'h0;
                    ph.hold   = wait_hold;
                end
                2'd1: begin
                    ph.en     = 1'b1;
                    ph.nibble = INIT_NIBBLE;
                    ph.hold   = pulse;
                end
                default: begin
                    ph.en     = 1'b0;
                    ph.nibble = INIT_NIBBLE;
                    ph.hold   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (adv) begin
            r_out <= ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (adv) begin
                if (last) begin
                    r_busy <= 1'b0;
                end
                r_step <= r_step + 5'd1;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_phase = r_out;

endmodule

FILE: src/char_lcd_nibble_sequencer.sv
// input path: queue entry, back-end job register, output register
// throughput: one phase beat per cycle from the back-end step counter
// unless stalled; 4 phases per command, char or goto job, 19 per init
// a 2-entry queue lets the front accept while the back end works
// reset (synchronous, active low) empties the queue and output stage and
// loads the timing registers with 1, 5, 1 and 100 ms
module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_byte_value,
    input  logic              i_row,
    input  logic [5:0]        i_col,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_reg_select,
    output logic              o_enable,
    output logic [3:0]        o_nibble,
    output logic [HOLD_W-1:0] o_hold_ms,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cfg   r_cfg;
    logic   push;
    t_job   front_job;
    logic   q_full;
    logic   q_valid;
    t_job   q_job;
    logic   pop;
    t_phase phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_hold     <= RST_PULSE_HOLD;
            r_cfg.command_settle <= RST_COMMAND_SETTLE;
            r_cfg.char_settle    <= RST_CHAR_SETTLE;
            r_cfg.init_wait      <= RST_INIT_WAIT;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PULSE_HOLD:     r_cfg.pulse_hold     <= i_cfg_data;
                CFG_COMMAND_SETTLE: r_cfg.command_settle <= i_cfg_data;
                CFG_CHAR_SETTLE:    r_cfg.char_settle    <= i_cfg_data;
                default:            r_cfg.init_wait      <= i_cfg_data;
            endcase
        end
    end

    lcdns_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_col        (i_col),
        .o_push       (push),
        .o_job        (front_job),
        .i_full       (q_full)
    );

    lcdns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    lcdns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_phase     (phase)
    );

    assign o_reg_select = phase.rs;
    assign o_enable     = phase.en;
    assign o_nibble     = phase.nibble;
    assign o_hold_ms    = phase.hold;
    assign o_last       = phase.last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_back.r_busy |-> (u_back.r_step <= INIT_LAST_STEP))
        else $error("step counter beyond init sequence");

    a_byte_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (u_back.r_busy && !u_back.r_job.init) |-> (u_back.r_step <= BYTE_LAST_STEP))
        else $error("byte job ran past four phases");

    a_strobe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_enable) |-> (o_hold_ms == {1'b0, r_cfg.pulse_hold}))
        else $error("enable-high phase with wrong hold");

    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_queue.r_count != 2'd3)
        else $error("queue overflow");

endmodule

FILE: tb/char_lcd_nibble_sequencer_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_tb;
    import lcdns_pkg::*;

    localparam int DIR_ROWS = 16;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        t_req       kind;
        logic [7:0] byte_value;
        logic       row;
        logic [5:0] col;
        logic       typed;
        logic       exp_rs;
        logic [7:0] exp_byte;
        logic [HOLD_W-1:0] exp_settle;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_req_type = REQ_COMMAND;
    logic [7:0]        i_byte_value = 8'h00;
    logic              i_row = 1'b0;
    logic [5:0]        i_col = 6'd0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_reg_select;
    logic              o_enable;
    logic [3:0]        o_nibble;
    logic [HOLD_W-1:0] o_hold_ms;
    logic              o_last;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = CFG_PULSE_HOLD;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    // timing registers as the block should hold them
    logic [CFG_W-1:0] set_pulse_hold     = RST_PULSE_HOLD;
    logic [CFG_W-1:0] set_command_settle = RST_COMMAND_SETTLE;
    logic [CFG_W-1:0] set_char_settle    = RST_CHAR_SETTLE;
    logic [CFG_W-1:0] set_init_wait      = RST_INIT_WAIT;

    t_phase   lcd_phase_q[$];
    t_phase   want_phase;
    t_dir_row dir_tab [DIR_ROWS];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int mismatches = 0;
    int phases_checked = 0;
    int requests_sent = 0;
    int inits_sent = 0;
    int settings_used = 1;

    char_lcd_nibble_sequencer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_col        (i_col),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_reg_select (o_reg_select),
        .o_enable     (o_enable),
        .o_nibble     (o_nibble),
        .o_hold_ms    (o_hold_ms),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void push_phase(logic rs, logic en, logic [3:0] nib,
                                       logic [HOLD_W-1:0] hold);
        t_phase p;
        p.rs = rs;
        p.en = en;
        p.nibble = nib;
        p.hold = hold;
        p.last = 1'b0;
        lcd_phase_q.push_back(p);
    endfunction

    function automatic void push_byte(logic rs, logic [7:0] b, logic [HOLD_W-1:0] pulse,
                                      logic [HOLD_W-1:0] settle);
        push_phase(rs, 1'b1, b[7:4], pulse);
        push_phase(rs, 1'b0, b[7:4], pulse);
        push_phase(rs, 1'b1, b[3:0], pulse);
        push_phase(rs, 1'b0, b[3:0], settle);
    endfunction

    function automatic void close_request();
        lcd_phase_q[lcd_phase_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void predict_request(t_req kind, logic [7:0] b, logic r,
                                            logic [5:0] c);
        logic [HOLD_W-1:0] pulse;
        logic [HOLD_W-1:0] cmd_settle;
        logic [HOLD_W-1:0] gap;
        logic [7:0]        addr;
        pulse = {1'b0, set_pulse_hold};
        cmd_settle = {1'b0, set_command_settle};
        gap = cmd_settle + {1'b0, set_init_wait};
        case (kind)
            REQ_COMMAND: push_byte(1'b0, b, pulse, cmd_settle);
            REQ_CHAR: push_byte(1'b1, b, pulse, {1'b0, set_char_settle});
            REQ_GOTO: begin
                addr = (r ? ROW1_BASE : ROW0_BASE) + {2'b00, c};
                push_byte(1'b0, addr, pulse, cmd_settle);
            end
            default: begin
                // power-up wait, lone nibble, then the four setup commands
                push_phase(1'b0, 1'b0, 4'h0, {1'b0, set_init_wait});
                push_phase(1'b0, 1'b1, INIT_NIBBLE, pulse);
                push_phase(1'b0, 1'b0, INIT_NIBBLE, '0);
                push_byte(1'b0, CMD_FUNCTION_SET, pulse, gap);
                push_byte(1'b0, CMD_DISPLAY_ON, pulse, gap);
                push_byte(1'b0, CMD_CLEAR, pulse, gap);
                push_byte(1'b0, CMD_ENTRY_MODE, pulse, cmd_settle);
            end
        endcase
        close_request();
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // pin phase checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (lcd_phase_q.size() == 0) begin
                $error("pin phase beat with nothing expected: nibble %h hold %0d",
                       o_nibble, o_hold_ms);
                mismatches++;
            end else begin
                want_phase = lcd_phase_q.pop_front();
                check_field("reg_select", want_phase.rs, o_reg_select);
                check_field("enable", want_phase.en, o_enable);
                check_field("nibble", want_phase.nibble, o_nibble);
                check_field("hold_ms", want_phase.hold, o_hold_ms);
                check_field("last", want_phase.last, o_last);
                phases_checked++;
            end
        end
    end

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && i_rst_n && $urandom_range(0, 4) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_req(t_req kind, logic [7:0] b, logic r, logic [5:0] c);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= kind;
        i_byte_value <= b;
        i_row <= r;
        i_col <= c;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
        if (kind == REQ_INIT) inits_sent++;
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_PULSE_HOLD: set_pulse_hold = val;
            CFG_COMMAND_SETTLE: set_command_settle = val;
            CFG_CHAR_SETTLE: set_char_settle = val;
            default: set_init_wait = val;
        endcase
    endtask

    task automatic retime(logic [CFG_W-1:0] pulse, logic [CFG_W-1:0] cmd,
                          logic [CFG_W-1:0] chr, logic [CFG_W-1:0] wait_ms);
        i_valid <= 1'b0;
        while (lcd_phase_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(CFG_PULSE_HOLD, pulse);
        write_reg(CFG_COMMAND_SETTLE, cmd);
        write_reg(CFG_CHAR_SETTLE, chr);
        write_reg(CFG_INIT_WAIT, wait_ms);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(int count, bit allow_idle);
        t_req kind;
        logic [7:0] b;
        logic r;
        logic [5:0] c;
        for (int n = 0; n < count; n++) begin
            if (n % 16 == 0) idle_on = allow_idle && ($urandom_range(0, 2) != 0);
            kind = t_req'($urandom_range(0, 2));
            if ($urandom_range(0, 11) == 0) kind = REQ_INIT;
            b = 8'($urandom);
            r = 1'($urandom);
            c = 6'($urandom);
            send_req(kind, b, r, c);
            predict_request(kind, b, r, c);
        end
    endtask

    initial begin
        #2_000_000;
        $display("char_lcd_nibble_sequencer_tb: FAIL");
        $finish;
    end

    initial begin
        dir_tab[0]  = '{REQ_COMMAND, 8'h00, 1'b0, 6'd0,  1'b1, 1'b0, 8'h00, 11'd5};
        dir_tab[1]  = '{REQ_COMMAND, 8'hFF, 1'b1, 6'd63, 1'b1, 1'b0, 8'hFF, 11'd5};
        dir_tab[2]  = '{REQ_CHAR,    8'h00, 1'b0, 6'd0,  1'b1, 1'b1, 8'h00, 11'd1};
        dir_tab[3]  = '{REQ_CHAR,    8'hFF, 1'b1, 6'd63, 1'b1, 1'b1, 8'hFF, 11'd1};
        dir_tab[4]  = '{REQ_GOTO,    8'hFF, 1'b0, 6'd0,  1'b1, 1'b0, 8'h80, 11'd5};
        dir_tab[5]  = '{REQ_GOTO,    8'h00, 1'b0, 6'd63, 1'b1, 1'b0, 8'hBF, 11'd5};
        dir_tab[6]  = '{REQ_GOTO,    8'h55, 1'b1, 6'd0,  1'b1, 1'b0, 8'hC0, 11'd5};
        dir_tab[7]  = '{REQ_GOTO,    8'hAA, 1'b1, 6'd63, 1'b1, 1'b0, 8'hFF, 11'd5};
        dir_tab[8]  = '{REQ_CHAR,    8'hA5, 1'b1, 6'd42, 1'b0, 1'b0, 8'h00, 11'd0};
        dir_tab[9]  = '{REQ_COMMAND, 8'h5A, 1'b1, 6'd21, 1'b0, 1'b0, 8'h00, 11'd0};
        dir_tab[10] = '{REQ_GOTO,    8'hFF, 1'b1, 6'd21, 1'b0, 1'b0, 8'h00, 11'd0};
        dir_tab[11] = '{REQ_INIT,    8'h00, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00, 11'd0};
        dir_tab[12] = '{REQ_INIT,    8'hFF, 1'b1, 6'd63, 1'b0, 1'b0, 8'h00, 11'd0};
        dir_tab[13] = '{REQ_CHAR,    8'h41, 1'b0, 6'd5,  1'b0, 1'b0, 8'h00, 11'd0};
        dir_tab[14] = '{REQ_COMMAND, 8'h01, 1'b0, 6'd9,  1'b0, 1'b0, 8'h00, 11'd0};
        dir_tab[15] = '{REQ_GOTO,    8'h3C, 1'b0, 6'd42, 1'b0, 1'b0, 8'h00, 11'd0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing: typed rows assume pulse hold 1
        for (int n = 0; n < DIR_ROWS; n++) begin
            send_req(dir_tab[n].kind, dir_tab[n].byte_value, dir_tab[n].row, dir_tab[n].col);
            if (dir_tab[n].typed) begin
                push_byte(dir_tab[n].exp_rs, dir_tab[n].exp_byte, 11'd1, dir_tab[n].exp_settle);
                close_request();
            end else begin
                predict_request(dir_tab[n].kind, dir_tab[n].byte_value, dir_tab[n].row,
                                dir_tab[n].col);
            end
        end

        retime('0, '0, '0, '0);
        run_random(80, 1'b1);
        retime('1, '1, '1, '1);
        run_random(60, 1'b1);
        retime(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        run_random(80, 1'b1);
        retime('1, '0, '1, '0);
        run_random(70, 1'b1);
        retime(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        idle_on = 1'b0;
        run_random(100, 1'b0);
        i_valid <= 1'b0;

        while (lcd_phase_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (lcd_phase_q.size() != 0) begin
            $error("%0d pin phases never arrived", lcd_phase_q.size());
            mismatches++;
        end

        $display("ran %0d requests (%0d init) under %0d timing settings", requests_sent,
                 inits_sent, settings_used);
        $display("compared %0d pin phase beats, %0d mismatches", phases_checked, mismatches);
        if (mismatches == 0) begin
            $display("char_lcd_nibble_sequencer_tb: PASS");
        end else begin
            $display("char_lcd_nibble_sequencer_tb: FAIL");
        end
        $finish;
    end

endmodule
